>>> design/ftgm_pkg.sv
// Package for the fan target block: shared types, register indexes,
// reading kinds and width helpers. No dependencies.
package ftgm_pkg;

   localparam int NUM_SLOTS_DEFAULT   = 8;
   localparam int MAP_ENTRIES_DEFAULT = 4;
   localparam int VALUE_W             = 32;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_HYST = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_HYST = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_E0    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_E1    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_E2    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_E3    = 3'd6;

   localparam logic [1:0] KIND_NUMERIC = 2'd0;
   localparam logic [1:0] KIND_MISSING = 2'd1;

   typedef struct packed {
      logic [VALUE_W-1:0]       drop_hysteresis;
      logic [VALUE_W-1:0]       rise_hysteresis;
      logic [2:0]               map_count;
      logic [3:0][63:0]         map_entry;
   } cfg_type;

   typedef struct packed {
      logic               go;
      logic [VALUE_W-1:0] value;
   } start_type;

   function automatic int addr_w(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

>>> design/ftgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftgm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [ftgm_pkg::addr_w(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [ftgm_pkg::addr_w(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ftgm_csr.sv
// Configuration registers: hysteresis, step table size and entries.
// Depends on ftgm_pkg.
module ftgm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ftgm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ftgm_pkg::CSR_DATA_W-1:0]       csr_data,
   output ftgm_pkg::cfg_type                     cfg_o
);

   localparam ftgm_pkg::cfg_type CFG_RESET = '{
      drop_hysteresis: '0,
      rise_hysteresis: '0,
      map_count:       3'd1,
      map_entry:       '0
   };

   ftgm_pkg::cfg_type cfg_ff;
   ftgm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ftgm_pkg::CSR_DROP_HYST: cfg_in.drop_hysteresis = csr_data[31:0];
            ftgm_pkg::CSR_RISE_HYST: cfg_in.rise_hysteresis = csr_data[31:0];
            ftgm_pkg::CSR_MAP_COUNT: cfg_in.map_count       = csr_data[2:0];
            ftgm_pkg::CSR_MAP_E0:    cfg_in.map_entry[0]    = csr_data;
            ftgm_pkg::CSR_MAP_E1:    cfg_in.map_entry[1]    = csr_data;
            ftgm_pkg::CSR_MAP_E2:    cfg_in.map_entry[2]    = csr_data;
            ftgm_pkg::CSR_MAP_E3:    cfg_in.map_entry[3]    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg_o     = cfg_ff;

endmodule

>>> design/ftgm_seq.sv
// Evaluation sequencer: one shared subtractor for hysteresis, step table walk
// and the max scan over the slot store; holds the result register.
// Depends on ftgm_pkg and ftgm_ram.
module ftgm_seq #(
   parameter int NUM_SLOTS   = ftgm_pkg::NUM_SLOTS_DEFAULT,
   parameter int MAP_ENTRIES = ftgm_pkg::MAP_ENTRIES_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ftgm_pkg::cfg_type                       cfg_i,
   input  ftgm_pkg::start_type                     start_i,
   input  logic [ftgm_pkg::addr_w(NUM_SLOTS)-1:0]  start_slot_i,
   output logic                                    busy_o,
   output logic                                    rsp_valid_o,
   input  logic                                    rsp_ready_i,
   output logic [ftgm_pkg::VALUE_W-1:0]            rsp_fan_target_o,
   output logic [ftgm_pkg::VALUE_W-1:0]            rsp_slot_speed_out_o
);

   localparam int SLOT_W = ftgm_pkg::addr_w(NUM_SLOTS);
   localparam int VW     = ftgm_pkg::VALUE_W;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CAP, S_GP, S_PG, S_HYST, S_KLO, S_KHI, S_WR, S_SCAN,
      S_LAST, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [VW-1:0]        g_ff, g_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [VW-1:0]        p_ff, p_in;
   logic [VW-1:0]        speed_ff, speed_in;
   logic [VW-1:0]        diff_ff, diff_in;
   logic                 lt_ff, lt_in;
   logic                 eq_ff, eq_in;
   logic                 trig_ff, trig_in;
   logic [1:0]           idx_ff, idx_in;
   logic                 ltk_ff, ltk_in;
   logic                 eqk_ff, eqk_in;
   logic [VW-1:0]        best_ff, best_in;
   logic [SLOT_W-1:0]    scan_ff, scan_in;
   logic                 pend_ff, pend_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]        rsp_target_ff, rsp_target_in;
   logic [VW-1:0]        rsp_speed_ff, rsp_speed_in;

   logic [VW-1:0]        sub_a;
   logic [VW-1:0]        sub_b;
   logic [VW:0]          sub_res;
   logic                 borrow;
   logic                 zero;
   logic [2:0]           n_eff;
   logic                 step_last;
   logic                 step_match;
   logic [1:0]           idx_next;

   logic                 ram_we;
   logic                 ram_re;
   logic [SLOT_W-1:0]    ram_raddr;
   logic [63:0]          ram_rdata;
   logic [VW-1:0]        rd_prev;
   logic [VW-1:0]        rd_speed;

   ftgm_ram #(
      .WIDTH (2 * VW),
      .DEPTH (NUM_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data ({g_ff, speed_ff}),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_prev  = ram_rdata[2*VW-1:VW] & {VW{rd_valid_ff}};
   assign rd_speed = ram_rdata[VW-1:0] & {VW{rd_valid_ff}};

   assign n_eff = (cfg_i.map_count > 3'(MAP_ENTRIES)) ? 3'(MAP_ENTRIES) : cfg_i.map_count;
   assign idx_next  = idx_ff + 2'd1;
   assign step_last = ({1'b0, idx_ff} + 3'd1) >= n_eff;

   always_comb begin
      case (state_ff)
         S_GP: begin
            sub_a = g_ff;
            sub_b = p_ff;
         end
         S_PG: begin
            sub_a = p_ff;
            sub_b = g_ff;
         end
         S_HYST: begin
            sub_a = lt_ff ? cfg_i.drop_hysteresis : cfg_i.rise_hysteresis;
            sub_b = diff_ff;
         end
         S_KLO: begin
            sub_a = g_ff;
            sub_b = cfg_i.map_entry[idx_ff][63:32];
         end
         S_KHI: begin
            sub_a = g_ff;
            sub_b = cfg_i.map_entry[idx_next][63:32];
         end
         default: begin
            sub_a = best_ff;
            sub_b = rd_speed;
         end
      endcase
      sub_res = {1'b0, sub_a} - {1'b0, sub_b};
      borrow  = sub_res[VW];
      zero    = (sub_res[VW-1:0] == '0);
   end

   assign step_match = ((idx_ff == 2'd0) && (ltk_ff || eqk_ff)) ||
                       (step_last && !ltk_ff) ||
                       (!step_last && !ltk_ff && borrow);

   always_comb begin
      state_in      = state_ff;
      g_in          = g_ff;
      slot_in       = slot_ff;
      p_in          = p_ff;
      speed_in      = speed_ff;
      diff_in       = diff_ff;
      lt_in         = lt_ff;
      eq_in         = eq_ff;
      trig_in       = trig_ff;
      idx_in        = idx_ff;
      ltk_in        = ltk_ff;
      eqk_in        = eqk_ff;
      best_in       = best_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready_i;
      rsp_target_in = rsp_target_ff;
      rsp_speed_in  = rsp_speed_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = slot_ff;

      if (pend_ff && borrow) begin
         best_in = rd_speed;
      end

      case (state_ff)
         S_IDLE: begin
            if (start_i.go) begin
               g_in     = start_i.value;
               slot_in  = start_slot_i;
               state_in = S_RD;
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = S_CAP;
         end
         S_CAP: begin
            p_in     = rd_prev;
            speed_in = rd_speed;
            state_in = S_GP;
         end
         S_GP: begin
            lt_in    = borrow;
            eq_in    = zero;
            diff_in  = sub_res[VW-1:0];
            state_in = S_PG;
         end
         S_PG: begin
            if (lt_ff) begin
               diff_in = sub_res[VW-1:0];
            end
            state_in = S_HYST;
         end
         S_HYST: begin
            trig_in = !eq_ff && borrow;
            idx_in  = 2'd0;
            if (!eq_ff && borrow && (n_eff != 3'd0)) begin
               state_in = S_KLO;
            end else begin
               state_in = S_WR;
            end
         end
         S_KLO: begin
            ltk_in   = borrow;
            eqk_in   = zero;
            state_in = S_KHI;
         end
         S_KHI: begin
            if (step_match) begin
               speed_in = cfg_i.map_entry[idx_ff][VW-1:0];
               state_in = S_WR;
            end else if (step_last) begin
               state_in = S_WR;
            end else begin
               idx_in   = idx_next;
               state_in = S_KLO;
            end
         end
         S_WR: begin
            if (trig_ff) begin
               ram_we            = 1'b1;
               valid_in[slot_ff] = 1'b1;
            end
            best_in  = '0;
            scan_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ram_re    = 1'b1;
            ram_raddr = scan_ff;
            pend_in   = 1'b1;
            if (scan_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = S_LAST;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_LAST: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready_i) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = best_ff;
               rsp_speed_in  = speed_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rd_valid_in = ram_re ? valid_ff[ram_raddr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      g_ff          <= g_in;
      slot_ff       <= slot_in;
      p_ff          <= p_in;
      speed_ff      <= speed_in;
      diff_ff       <= diff_in;
      lt_ff         <= lt_in;
      eq_ff         <= eq_in;
      trig_ff       <= trig_in;
      idx_ff        <= idx_in;
      ltk_ff        <= ltk_in;
      eqk_ff        <= eqk_in;
      best_ff       <= best_in;
      scan_ff       <= scan_in;
      rsp_target_ff <= rsp_target_in;
      rsp_speed_ff  <= rsp_speed_in;
   end

   assign busy_o               = (state_ff != S_IDLE);
   assign rsp_valid_o          = rsp_valid_ff;
   assign rsp_fan_target_o     = rsp_target_ff;
   assign rsp_slot_speed_out_o = rsp_speed_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_i.go |-> (state_ff == S_IDLE))
      else $error("evaluation started while sequencer busy");

   a_write_trig: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (trig_ff && (state_ff == S_WR)))
      else $error("slot store written without re-map");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KLO) |-> ({1'b0, idx_ff} < n_eff))
      else $error("step table walk past active entries");

   a_result_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_speed_ff <= rsp_target_ff))
      else $error("slot speed exceeds zone target");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LAST) |=> (state_ff == S_DONE))
      else $error("scan did not complete");

endmodule

>>> design/fan_target_from_group_max.sv
// Fan zone target block: gathers the group maximum of sensor readings, then
// runs the slot evaluation. Depends on ftgm_pkg, ftgm_csr and ftgm_seq.
//
// Usage:
//   req_* carries one member reading per transfer. Readings of kind missing
//   are dropped, a reading of any other non-numeric kind drops the rest of its
//   group. A reading is taken whenever req_ready is high.
//   On eval_last with at least one numeric reading, the sequencer reads the
//   slot, compares against the hysteresis and, if the change exceeds it, walks
//   the step table and writes the slot; it then scans all slots for the
//   maximum into the result register; req_ready is low meanwhile.
//   An evaluation without numeric readings gives no rsp transfer.
//   rsp_* holds one finished result; the block accepts further readings
//   while it waits, and the next evaluation stalls in its last step until
//   the receiver takes the held result.
//   csr_* writes registers, always ready; write only when idle.
//   Reset (synchronous) clears the group state, all slot speeds and group
//   values to zero, and loads the register defaults (map_count = 1).
module fan_target_from_group_max #(
   parameter int NUM_SLOTS   = ftgm_pkg::NUM_SLOTS_DEFAULT,
   parameter int MAP_ENTRIES = ftgm_pkg::MAP_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_slot,
   input  logic [31:0]                       req_member_value,
   input  logic [1:0]                        req_member_kind,
   input  logic                              req_group_last,
   input  logic                              req_eval_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_fan_target,
   output logic [31:0]                       rsp_slot_speed_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ftgm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ftgm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int SLOT_W = ftgm_pkg::addr_w(NUM_SLOTS);

   ftgm_pkg::cfg_type   cfg;
   ftgm_pkg::start_type start;
   logic                busy;
   logic                take;
   logic [31:0]         max_ff, max_in, max_upd;
   logic                have_ff, have_in, have_upd;
   logic                skip_ff, skip_in;
   logic [6:0]          slot_rem;

   assign req_ready = !busy;
   assign take      = req_valid && req_ready;

   always_comb begin
      max_upd  = max_ff;
      have_upd = have_ff;
      skip_in  = skip_ff;
      if (!skip_ff) begin
         if (req_member_kind == ftgm_pkg::KIND_NUMERIC) begin
            if (!have_ff || (req_member_value > max_ff)) begin
               max_upd = req_member_value;
            end
            have_upd = 1'b1;
         end else if (req_member_kind != ftgm_pkg::KIND_MISSING) begin
            skip_in = 1'b1;
         end
      end
      if (req_group_last || req_eval_last) begin
         skip_in = 1'b0;
      end
      max_in  = max_upd;
      have_in = have_upd;
      if (req_eval_last) begin
         max_in  = '0;
         have_in = 1'b0;
      end
      if (!take) begin
         max_in  = max_ff;
         have_in = have_ff;
         skip_in = skip_ff;
      end
   end

   always_comb begin
      slot_rem = {4'd0, req_slot};
      for (int i = 0; i < 8; i++) begin
         if (slot_rem >= 7'(NUM_SLOTS)) begin
            slot_rem = slot_rem - 7'(NUM_SLOTS);
         end
      end
   end

   assign start.go    = take && req_eval_last && have_upd;
   assign start.value = max_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         have_ff <= 1'b0;
         skip_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         have_ff <= have_in;
         skip_ff <= skip_in;
      end
   end

   ftgm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_o     (cfg)
   );

   ftgm_seq #(
      .NUM_SLOTS   (NUM_SLOTS),
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_seq (
      .clock                (clock),
      .reset                (reset),
      .cfg_i                (cfg),
      .start_i              (start),
      .start_slot_i         (slot_rem[SLOT_W-1:0]),
      .busy_o               (busy),
      .rsp_valid_o          (rsp_valid),
      .rsp_ready_i          (rsp_ready),
      .rsp_fan_target_o     (rsp_fan_target),
      .rsp_slot_speed_out_o (rsp_slot_speed_out)
   );

endmodule
